// ===== rtl/ug2c_pkg.sv =====
`default_nettype none

package ug2c_pkg;

  localparam int unsigned MaxLen = 256;
  localparam int unsigned CntW   = $clog2(MaxLen);
  localparam logic [CntW-1:0] LimitCount = CntW'(MaxLen - 2);

  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);

  localparam logic [7:0] LeadMin   = 8'hC0;
  localparam logic [7:0] LeadCe    = 8'hCE;
  localparam logic [7:0] LeadCf    = 8'hCF;
  localparam logic [1:0] ContTag   = 2'b10;
  localparam logic [7:0] AsciiLowA = 8'h61;
  localparam logic [7:0] AsciiLowZ = 8'h7A;
  localparam logic [7:0] CaseShift = 8'h20;

  typedef logic [7:0] byte_t;

  // One queue entry holds the one or two output bytes caused by an input beat.
  typedef struct packed {
    logic  pair;
    byte_t byte0;
    logic  last0;
    byte_t byte1;
    logic  last1;
  } cmd_t;

  localparam byte_t GreekCe [64] = '{
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hD5, 8'hC1, 8'h00,
    8'hC5, 8'hC7, 8'hC9, 8'h00, 8'hCF, 8'h00, 8'hD5, 8'hD9,
    8'hC9, 8'hC1, 8'hC2, 8'hC3, 8'hC4, 8'hC5, 8'hC6, 8'hC7,
    8'hC8, 8'hC9, 8'hCA, 8'hCB, 8'hCC, 8'hCD, 8'hCE, 8'hCF,
    8'hD0, 8'hD1, 8'h00, 8'hD3, 8'hD4, 8'hD5, 8'hD6, 8'hD7,
    8'hD8, 8'hD9, 8'hC9, 8'hD5, 8'hC1, 8'hC5, 8'hC7, 8'hC9,
    8'h00, 8'hC1, 8'hC2, 8'hC3, 8'hC4, 8'hC5, 8'hC6, 8'hC7,
    8'hC8, 8'hC9, 8'hCA, 8'hCB, 8'hCC, 8'hCD, 8'hCE, 8'hCF
  };

  localparam byte_t GreekCf [16] = '{
    8'hD0, 8'hD1, 8'hD3, 8'hD3, 8'hD4, 8'hD5, 8'hD6, 8'hD7,
    8'hD8, 8'hD9, 8'hC9, 8'hD5, 8'hCF, 8'hD5, 8'hD9, 8'h00
  };

  // Returns zero when the pair has no single-byte code.
  function automatic byte_t map_pair(input byte_t lead, input byte_t follow);
    byte_t res;
    res = 8'h00;
    if (follow[7:6] == ContTag) begin
      if (lead == LeadCe) begin
        res = GreekCe[follow[5:0]];
      end else if (lead == LeadCf && follow[5:4] == 2'b00) begin
        res = GreekCf[follow[3:0]];
      end
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/ug2c_ifs.sv =====
`default_nettype none

interface ug2c_in_if;
  logic                valid;
  logic                ready;
  ug2c_pkg::byte_t     in_byte;
  logic                in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

interface ug2c_out_if;
  logic                valid;
  logic                ready;
  ug2c_pkg::byte_t     out_byte;
  logic                out_last;

  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink (input valid, input out_byte, input out_last, output ready);
endinterface

`default_nettype wire

// ===== rtl/utf8_greek_to_cp1253_upper_core.sv =====
// Converts a UTF-8 byte stream to Windows-1253, turning each Greek letter pair
// with lead byte 0xCE or 0xCF into the single code of its accent-free capital,
// passing all other bytes through and optionally folding ASCII a-z to A-Z.
// An input beat is accepted in every cycle while the four-entry queue between
// the decode front end and the output stage has room; a beat that yields two
// bytes (an unmapped lead followed by another byte) occupies the single output
// register for both bytes in turn, so the sustained rate is one input beat per
// cycle for streams without such pairs while the output side is ready.
// Strings are cut after 255 bytes and the rest up to the marked final byte
// is discarded. The fold setting is written through the config port, which
// is always ready, and must be changed only while the block is idle.

`default_nettype none

module utf8_greek_to_cp1253_upper_core (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  ug2c_in_if.sink      in_ch,
  ug2c_out_if.source   out_ch,
  input  wire logic    cfg_valid_i,
  output logic         cfg_ready_o,
  input  wire logic    cfg_fold_ascii_upper_i
);

  logic              fold_q;
  ug2c_pkg::cmd_t    push_cmd;
  logic              push;
  logic              q_full;
  ug2c_pkg::cmd_t    head;
  logic              q_empty;
  logic              pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fold_q <= 1'b0;
    end else if (cfg_valid_i) begin
      fold_q <= cfg_fold_ascii_upper_i;
    end
  end

  ug2c_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_ch    (in_ch),
    .q_full_i (q_full),
    .cmd_o    (push_cmd),
    .push_o   (push)
  );

  ug2c_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (q_full),
    .pop_i   (pop),
    .head_o  (head),
    .empty_o (q_empty)
  );

  ug2c_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fold_i  (fold_q),
    .head_i  (head),
    .empty_i (q_empty),
    .pop_o   (pop),
    .out_ch  (out_ch)
  );

endmodule

`default_nettype wire

// ===== rtl/ug2c_front.sv =====
`default_nettype none

module ug2c_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  ug2c_in_if.sink            in_ch,
  input  wire logic          q_full_i,
  output ug2c_pkg::cmd_t     cmd_o,
  output logic               push_o
);

  logic                        wait_q, wait_d;
  ug2c_pkg::byte_t             lead_q, lead_d;
  logic [ug2c_pkg::CntW-1:0]   cnt_q, cnt_d;
  logic                        drop_q, drop_d;
  logic                        accept;
  logic                        at_end;
  ug2c_pkg::byte_t             mapped;

  assign in_ch.ready = !q_full_i;
  assign accept      = in_ch.valid && !q_full_i;
  assign at_end      = in_ch.in_last || (cnt_q >= ug2c_pkg::LimitCount);
  assign mapped      = ug2c_pkg::map_pair(lead_q, in_ch.in_byte);

  always_comb begin
    wait_d = wait_q;
    lead_d = lead_q;
    cnt_d  = cnt_q;
    drop_d = drop_q;
    push_o = 1'b0;
    cmd_o  = '0;
    if (accept) begin
      if (drop_q) begin
        if (in_ch.in_last) begin
          drop_d = 1'b0;
        end
      end else begin
        cnt_d = cnt_q + 1'b1;
        if (wait_q && mapped != 8'h00) begin
          push_o       = 1'b1;
          cmd_o.byte0  = mapped;
          cmd_o.last0  = at_end;
          wait_d       = 1'b0;
        end else begin
          wait_d = 1'b0;
          if (in_ch.in_byte < ug2c_pkg::LeadMin || at_end) begin
            push_o = 1'b1;
            if (wait_q) begin
              cmd_o.pair  = 1'b1;
              cmd_o.byte0 = lead_q;
              cmd_o.last0 = 1'b0;
              cmd_o.byte1 = in_ch.in_byte;
              cmd_o.last1 = at_end;
            end else begin
              cmd_o.byte0 = in_ch.in_byte;
              cmd_o.last0 = at_end;
            end
          end else begin
            if (wait_q) begin
              push_o      = 1'b1;
              cmd_o.byte0 = lead_q;
              cmd_o.last0 = 1'b0;
            end
            wait_d = 1'b1;
            lead_d = in_ch.in_byte;
          end
        end
        if (at_end) begin
          wait_d = 1'b0;
          lead_d = 8'h00;
          cnt_d  = '0;
          drop_d = !in_ch.in_last;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wait_q <= 1'b0;
      lead_q <= 8'h00;
      cnt_q  <= '0;
      drop_q <= 1'b0;
    end else begin
      wait_q <= wait_d;
      lead_q <= lead_d;
      cnt_q  <= cnt_d;
      drop_q <= drop_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ug2c_queue.sv =====
`default_nettype none

module ug2c_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire ug2c_pkg::cmd_t  cmd_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output ug2c_pkg::cmd_t       head_o,
  output logic                 empty_o
);

  ug2c_pkg::cmd_t                mem_q [ug2c_pkg::QDepth];
  logic [ug2c_pkg::QPtrW-1:0]    wr_q, wr_d;
  logic [ug2c_pkg::QPtrW-1:0]    rd_q, rd_d;
  logic [ug2c_pkg::QPtrW:0]      cnt_q, cnt_d;
  logic                          do_push;
  logic                          do_pop;

  assign full_o  = (cnt_q == (ug2c_pkg::QPtrW+1)'(ug2c_pkg::QDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_d  = do_push ? wr_q + 1'b1 : wr_q;
    rd_d  = do_pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ug2c_back.sv =====
`default_nettype none

module ug2c_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            fold_i,
  input  wire ug2c_pkg::cmd_t  head_i,
  input  wire logic            empty_i,
  output logic                 pop_o,
  ug2c_out_if.source           out_ch
);

  logic              valid_q, valid_d;
  logic              sel_q, sel_d;
  ug2c_pkg::byte_t   byte_q;
  logic              last_q;
  logic              load;
  logic              take;
  ug2c_pkg::byte_t   raw;
  ug2c_pkg::byte_t   folded;
  logic              raw_last;

  assign load     = !valid_q || out_ch.ready;
  assign take     = load && !empty_i;
  assign raw      = sel_q ? head_i.byte1 : head_i.byte0;
  assign raw_last = sel_q ? head_i.last1 : head_i.last0;
  assign pop_o    = take && (!head_i.pair || sel_q);

  always_comb begin
    folded = raw;
    if (fold_i && raw >= ug2c_pkg::AsciiLowA && raw <= ug2c_pkg::AsciiLowZ) begin
      folded = raw - ug2c_pkg::CaseShift;
    end
    sel_d   = take ? (head_i.pair && !sel_q) : sel_q;
    valid_d = take ? 1'b1 : (load ? 1'b0 : valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      sel_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      sel_q   <= sel_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      byte_q <= folded;
      last_q <= raw_last;
    end
  end

  assign out_ch.valid    = valid_q;
  assign out_ch.out_byte = byte_q;
  assign out_ch.out_last = last_q;

endmodule

`default_nettype wire
